// ----- rtl/core/rcl_pkg.sv -----
// Package for the ranked character list: sizes, operation and status codes,
// and the request, result and internal command types.
// Depends on nothing; every other file in rtl/core uses it.
`default_nettype none

package rcl_pkg;

  localparam int CAPACITY = 32;
  localparam int IdxW     = $clog2(CAPACITY);
  localparam int CntW     = $clog2(CAPACITY + 1);
  localparam int PosW     = 6;
  localparam int ElemW    = 8;
  localparam int CmpW     = ((PosW > CntW) ? PosW : CntW) + 1;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_GET   = 2'd2,
    OP_PRINT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_DEL   = 3'd1,
    CMD_GET   = 3'd2,
    CMD_PRINT = 3'd3,
    CMD_REPLY = 3'd4
  } cmd_e;

  typedef struct packed {
    op_e              op;
    logic [PosW-1:0]  position;
    logic [ElemW-1:0] element;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [ElemW-1:0] element_out;
    logic             data_valid;
    logic             last;
  } out_t;

  typedef struct packed {
    cmd_e             kind;
    status_e          status;
    logic [IdxW-1:0]  idx;
    logic [ElemW-1:0] element;
    logic [CntW-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/rcl_front.sv -----
// Front end of the ranked character list: accepts requests, checks ranks
// against its own element count and turns each request into a command.
// Depends on rcl_pkg.
`default_nettype none

module rcl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rcl_pkg::in_t  req_i,
  input  wire logic          q_full_i,
  output logic               busy_o,
  output logic               push_o,
  output rcl_pkg::cmd_t      cmd_o
);

  logic [rcl_pkg::CntW-1:0] count_q, count_d;
  logic [rcl_pkg::CmpW-1:0] pos_w, cnt_w;
  logic                     pos_zero;

  assign busy_o   = q_full_i;
  assign push_o   = start_i & ~q_full_i;
  assign pos_w    = rcl_pkg::CmpW'(req_i.position);
  assign cnt_w    = rcl_pkg::CmpW'(count_q);
  assign pos_zero = (pos_w == '0);

  // The count changes as soon as a command is classified, since every
  // accepted add or delete is certain to be carried out by the back end.
  always_comb begin
    count_d         = count_q;
    cmd_o.kind      = rcl_pkg::CMD_REPLY;
    cmd_o.status    = rcl_pkg::STATUS_OK;
    cmd_o.idx       = rcl_pkg::IdxW'(pos_w - rcl_pkg::CmpW'(1));
    cmd_o.element   = req_i.element;
    cmd_o.len       = count_q;
    case (req_i.op)
      rcl_pkg::OP_ADD: begin
        if (pos_zero || (pos_w > cnt_w + rcl_pkg::CmpW'(1))) begin
          cmd_o.status = rcl_pkg::STATUS_BAD_POS;
        end else if (cnt_w == rcl_pkg::CmpW'(rcl_pkg::CAPACITY)) begin
          cmd_o.status = rcl_pkg::STATUS_FULL;
        end else begin
          cmd_o.kind = rcl_pkg::CMD_ADD;
          count_d    = count_q + rcl_pkg::CntW'(1);
        end
      end
      rcl_pkg::OP_DEL: begin
        if (pos_zero || (pos_w > cnt_w)) begin
          cmd_o.status = rcl_pkg::STATUS_BAD_POS;
        end else begin
          cmd_o.kind = rcl_pkg::CMD_DEL;
          count_d    = count_q - rcl_pkg::CntW'(1);
        end
      end
      rcl_pkg::OP_GET: begin
        if (pos_zero || (pos_w > cnt_w)) begin
          cmd_o.status = rcl_pkg::STATUS_BAD_POS;
        end else begin
          cmd_o.kind = rcl_pkg::CMD_GET;
        end
      end
      rcl_pkg::OP_PRINT: begin
        cmd_o.kind = rcl_pkg::CMD_PRINT;
      end
      default: begin
        cmd_o.kind = rcl_pkg::CMD_REPLY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_o) begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rcl_queue.sv -----
// Short command queue between the front and back ends of the ranked
// character list. Depends on rcl_pkg.
`default_nettype none

module rcl_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rcl_pkg::cmd_t push_cmd_i,
  input  wire logic          pop_i,
  output rcl_pkg::cmd_t      head_o,
  output logic               empty_o,
  output logic               full_o
);

  rcl_pkg::cmd_t             mem_q [rcl_pkg::QDepth];
  logic [rcl_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rcl_pkg::QCntW-1:0] cnt_q;
  logic                      do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == rcl_pkg::QCntW'(rcl_pkg::QDepth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == rcl_pkg::QPtrW'(rcl_pkg::QDepth - 1)) ?
                    '0 : wr_ptr_q + rcl_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == rcl_pkg::QPtrW'(rcl_pkg::QDepth - 1)) ?
                    '0 : rd_ptr_q + rcl_pkg::QPtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + rcl_pkg::QCntW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - rcl_pkg::QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rcl_back.sv -----
// Back end of the ranked character list: the shift-register row of
// elements, command execution and the print streamer. Depends on rcl_pkg.
`default_nettype none

module rcl_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rcl_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               res_valid_o,
  output rcl_pkg::out_t      res_o
);

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_PRINT = 2'b10
  } bk_state_e;

  bk_state_e                 state_q, state_d;
  logic [rcl_pkg::ElemW-1:0] row_q [rcl_pkg::CAPACITY];
  logic [rcl_pkg::ElemW-1:0] row_d [rcl_pkg::CAPACITY];
  logic [rcl_pkg::IdxW-1:0]  pidx_q, pidx_d, rd_idx;
  logic [rcl_pkg::CntW-1:0]  len_q, len_d;
  logic [rcl_pkg::ElemW-1:0] rd_data;
  logic                      print_last;
  logic                      res_valid_d;
  rcl_pkg::out_t             res_d, res_q;
  logic                      res_valid_q;

  // A single read port serves both get and the print stream.
  assign rd_idx     = (state_q == BK_PRINT) ? pidx_q : head_i.idx;
  assign rd_data    = row_q[rd_idx];
  assign print_last = ((rcl_pkg::CntW'(pidx_q) + rcl_pkg::CntW'(1)) == len_q);
  assign pop_o      = (state_q == BK_IDLE) & ~empty_i;

  always_comb begin
    state_d             = state_q;
    pidx_d              = pidx_q;
    len_d               = len_q;
    row_d               = row_q;
    res_valid_d         = 1'b0;
    res_d.status        = rcl_pkg::STATUS_OK;
    res_d.element_out   = '0;
    res_d.data_valid    = 1'b0;
    res_d.last          = 1'b1;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          case (head_i.kind)
            rcl_pkg::CMD_ADD: begin
              res_valid_d = 1'b1;
              row_d[0] = (head_i.idx == '0) ? head_i.element : row_q[0];
              for (int i = 1; i < rcl_pkg::CAPACITY; i++) begin
                if (rcl_pkg::IdxW'(i) > head_i.idx) begin
                  row_d[i] = row_q[i-1];
                end else if (rcl_pkg::IdxW'(i) == head_i.idx) begin
                  row_d[i] = head_i.element;
                end
              end
            end
            rcl_pkg::CMD_DEL: begin
              res_valid_d = 1'b1;
              for (int i = 0; i < rcl_pkg::CAPACITY - 1; i++) begin
                if (rcl_pkg::IdxW'(i) >= head_i.idx) begin
                  row_d[i] = row_q[i+1];
                end
              end
            end
            rcl_pkg::CMD_GET: begin
              res_valid_d       = 1'b1;
              res_d.element_out = rd_data;
              res_d.data_valid  = 1'b1;
            end
            rcl_pkg::CMD_PRINT: begin
              if (head_i.len == '0) begin
                res_valid_d = 1'b1;
              end else begin
                state_d = BK_PRINT;
                pidx_d  = '0;
                len_d   = head_i.len;
              end
            end
            rcl_pkg::CMD_REPLY: begin
              res_valid_d  = 1'b1;
              res_d.status = head_i.status;
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end
      BK_PRINT: begin
        res_valid_d       = 1'b1;
        res_d.element_out = rd_data;
        res_d.data_valid  = 1'b1;
        res_d.last        = print_last;
        pidx_d            = pidx_q + rcl_pkg::IdxW'(1);
        if (print_last) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    res_q  <= res_d;
    pidx_q <= pidx_d;
    len_q  <= len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/ranked_char_list_top.sv -----
// Top level of the ranked character list: front end, command queue and
// back end. Depends on rcl_pkg, rcl_front, rcl_queue and rcl_back.
`default_nettype none

// The block keeps an ordered list of up to CAPACITY bytes addressed by
// 1-based rank and executes add, delete, get and print requests. A request
// is taken at a clock edge where start_i is high and busy_o is low. Every
// result appears on res_o for exactly one cycle with res_valid_o high, and
// the receiver must take it then, because the block cannot be stalled from
// the result side. Add, delete, get and rejected requests each give one
// result, held first in the command queue and then in the result register,
// and a run of them is sustained at one request per cycle while no print
// holds the back end. A print occupies the back end while the stored elements
// stream out (a single result when the list is empty), since the row has a
// single read port that streams one element per cycle; during that time up
// to two further requests wait in the command queue, and busy_o rises once
// the queue is full. Ranks are checked in the front end against its own
// element count, so the status of a request never waits on the back end.

module ranked_char_list_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire rcl_pkg::in_t req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output rcl_pkg::out_t     res_o
);

  rcl_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, q_empty, q_full;

  // The front end classifies each request and tracks the element count.
  rcl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .req_i    (req_i),
    .q_full_i (q_full),
    .busy_o   (busy_o),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // The queue lets the front end keep accepting while a print streams.
  rcl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // The back end owns the element row and drives the registered results.
  rcl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
